// ===== design/ptmgq_pkg.sv =====
// shared types, constants and constant functions for the tone mapping core
package ptmgq_pkg;

  // input channels per pixel
  localparam int NumChannels = 4;
  // channel select width
  localparam int SelWidth = $clog2(NumChannels);
  // fraction bits of the log and exp fractions
  localparam int LogBits = 24;
  // register stages inside one colour lane
  localparam int LaneDepth = 9 + 2 * LogBits;

  // configuration register indexes
  typedef enum logic [2:0] {
    CfgWindowLow   = 3'd0,
    CfgWindowScale = 3'd1,
    CfgGammaStep   = 3'd2,
    CfgHlEnable    = 3'd3,
    CfgHlLevel     = 3'd4,
    CfgSelRed      = 3'd5,
    CfgSelGreen    = 3'd6,
    CfgSelBlue     = 3'd7
  } ptmgq_cfg_idx_e;

  // window and gamma settings seen by each lane
  typedef struct packed {
    logic signed [31:0] window_low;
    logic [31:0]        window_scale;
    logic signed [5:0]  gamma_step;
  } ptmgq_cfg_t;

  // exponent scaling derived from the gamma step
  typedef struct packed {
    logic [4:0]  shamt;
    logic [16:0] base;
  } ptmgq_gamma_t;

  // split step into tenths: base is 2^(r/10) in Q16, shift is 20 - q
  function automatic ptmgq_gamma_t ptmgq_gamma_split(logic signed [5:0] step);
    logic [6:0]   t;
    logic [2:0]   q;
    logic [6:0]   r;
    ptmgq_gamma_t g;
    t = 7'({step[5], step}) + 7'd40;
    q = '0;
    for (int k = 1; k < 8; k++) begin
      if (t >= 7'(10 * k)) q = 3'(k);
    end
    r = t - 7'(10 * int'(q));
    g.shamt = 5'(20 - int'(q));
    unique case (r)
      7'd0:    g.base = 17'd65536;
      7'd1:    g.base = 17'd70240;
      7'd2:    g.base = 17'd75281;
      7'd3:    g.base = 17'd80684;
      7'd4:    g.base = 17'd86475;
      7'd5:    g.base = 17'd92682;
      7'd6:    g.base = 17'd99334;
      7'd7:    g.base = 17'd106464;
      7'd8:    g.base = 17'd114105;
      7'd9:    g.base = 17'd122295;
      default: g.base = 17'd65536;
    endcase
    return g;
  endfunction

  // floor square root, used at elaboration only
  function automatic logic [63:0] ptmgq_isqrt(logic [63:0] a);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] b;
    rem = a;
    r   = '0;
    b   = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q30 factor 2^(-2^-idx) built by repeated square roots
  function automatic logic [63:0] ptmgq_exp_coef(int idx);
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int i = 0; i < idx; i++) begin
      c = ptmgq_isqrt(c << 30);
    end
    return c;
  endfunction

endpackage

// ===== design/ptmgq_lane.sv =====
// one colour lane: window, clamp, gamma by log and exp, byte rounding
module ptmgq_lane import ptmgq_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  ptmgq_cfg_t         cfg_i,
  input  logic signed [31:0] sample_i,
  output logic [7:0]         byte_o
);

  // positive part of sample minus window low
  logic signed [32:0] diff;
  logic [31:0]        dpos_q;
  assign diff = {sample_i[31], sample_i} - {cfg_i.window_low[31], cfg_i.window_low};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dpos_q <= (diff > 0) ? diff[31:0] : '0;
    end
  end

  // partial products of the window scale
  logic [47:0] pp_lo_q;
  logic [47:0] pp_hi_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_lo_q <= 48'(dpos_q) * 48'(cfg_i.window_scale[15:0]);
      pp_hi_q <= 48'(dpos_q) * 48'(cfg_i.window_scale[31:16]);
    end
  end

  // sum, saturate at one, round to Q16
  logic [64:0] psum;
  logic [32:0] prnd;
  logic [16:0] vnew;
  logic        bypass;
  logic [16:0] v_q   [2:LaneDepth-2];
  logic        byp_q [2:LaneDepth-2];

  assign psum   = {17'd0, pp_lo_q} + {1'b0, pp_hi_q, 16'd0};
  assign prnd   = {1'b0, psum[31:0]} + 33'd32768;
  assign vnew   = (|psum[64:32]) ? 17'h10000 : prnd[32:16];
  assign bypass = (cfg_i.gamma_step == '0) || (vnew == '0) || (vnew == 17'h10000);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[2]   <= vnew;
      byp_q[2] <= bypass;
    end
  end

  // carry the linear value along for the bypass case
  for (genvar k = 3; k <= LaneDepth - 2; k++) begin : g_vcarry
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k]   <= v_q[k-1];
        byp_q[k] <= byp_q[k-1];
      end
    end
  end

  // leading one and Q30 mantissa
  logic [3:0]  lead;
  logic [30:0] x_q    [0:LogBits];
  logic [3:0]  lead_q [0:LogBits];
  logic [23:0] lf_q   [1:LogBits];

  always_comb begin
    lead = '0;
    for (int b = 0; b < 16; b++) begin
      if (v_q[2][b]) lead = 4'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= {15'd0, v_q[2][15:0]} << (5'd30 - {1'b0, lead});
      lead_q[0] <= lead;
    end
  end

  // log2 fraction, one bit per squaring
  for (genvar j = 0; j < LogBits; j++) begin : g_log
    logic [61:0] sq;
    logic [31:0] sqs;
    logic [23:0] lf_prev;
    assign sq  = 62'(x_q[j]) * 62'(x_q[j]);
    assign sqs = sq[61:30];
    if (j == 0) begin : g_first
      assign lf_prev = '0;
    end else begin : g_next
      assign lf_prev = lf_q[j];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[j+1]    <= sqs[31] ? sqs[31:1] : sqs[30:0];
        lf_q[j+1]   <= {lf_prev[22:0], sqs[31]};
        lead_q[j+1] <= lead_q[j];
      end
    end
  end

  // negative log in Q24
  logic [28:0] lg_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lg_q <= {5'd16 - {1'b0, lead_q[LogBits]}, 24'd0} - {5'd0, lf_q[LogBits]};
    end
  end

  // scale by the gamma exponent
  ptmgq_gamma_t gsplit;
  logic [45:0]  gprod_q;
  assign gsplit = ptmgq_gamma_split(cfg_i.gamma_step);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gprod_q <= 46'(lg_q) * 46'(gsplit.base);
    end
  end

  // integer and fraction of the exponent
  logic [45:0] mexp;
  logic [23:0] f_q    [0:LogBits-1];
  logic [4:0]  n_q    [0:LogBits];
  logic        zero_q [0:LogBits];
  assign mexp = gprod_q >> gsplit.shamt;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q[0]    <= mexp[23:0];
      n_q[0]    <= mexp[28:24];
      zero_q[0] <= (mexp[45:24] >= 22'd18);
    end
  end

  // 2^-f by products of 2^(-2^-j) factors
  logic [30:0] t_q [1:LogBits];
  for (genvar j = 1; j <= LogBits; j++) begin : g_exp
    localparam logic [29:0] Coef = 30'(ptmgq_exp_coef(j));
    logic [30:0] tin;
    logic [60:0] tm;
    if (j == 1) begin : g_first
      assign tin = 31'h4000_0000;
    end else begin : g_next
      assign tin = t_q[j-1];
    end
    assign tm = 61'(tin) * 61'(Coef);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[j]    <= f_q[j-1][LogBits-j] ? tm[60:30] : tin;
        n_q[j]    <= n_q[j-1];
        zero_q[j] <= zero_q[j-1];
      end
    end
    if (j < LogBits) begin : g_fcarry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          f_q[j] <= f_q[j-1];
        end
      end
    end
  end

  // integer part as a rounding right shift
  logic [4:0]  esh;
  logic [32:0] esum;
  logic [32:0] eshr;
  logic [16:0] y_q;
  assign esh  = 5'd14 + n_q[LogBits];
  assign esum = {2'b0, t_q[LogBits]} + {1'b0, 32'd1 << (esh - 5'd1)};
  assign eshr = esum >> esh;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= zero_q[LogBits] ? '0 : eshr[16:0];
    end
  end

  // times 255, rounded to a byte
  logic [16:0] val;
  logic [24:0] bsum;
  logic [7:0]  byte_q;
  assign val  = byp_q[LaneDepth-2] ? v_q[LaneDepth-2] : y_q;
  assign bsum = {val, 8'd0} - {8'd0, val} + 25'd32768;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byte_q <= bsum[23:16];
    end
  end

  assign byte_o = byte_q;

endmodule

// ===== design/pixel_tone_map_gamma_quantize_core.sv =====
// top level: channel select, highlight and bad marking, lanes and output skid
//
// Pixels arrive on the input channel (in_valid_i / in_stall_o) with four
// signed Q16.16 samples and a non-finite flag per channel; one byte triple
// leaves per pixel on the output channel (out_valid_o / out_stall_i).
// A request is taken whenever valid is high and stall is low.
// Settings are written on the cfg channel (cfg_valid_i, cfg_ready_o, always
// ready); the user must write them only while no pixel is in flight, as
// the block itself does not enforce this. Throughput is one pixel per clock
// while the skid is empty. The select register loads at the accepting edge,
// then 57 lane stages and the output register follow; the lane depth comes
// from 24 squaring stages of the log and 24 product stages of the exponent,
// one 31-bit multiplier each.
// When the receiver stalls, the output register holds and one further
// result lands in a skid register; with the skid full the whole pipeline
// freezes and in_stall_o rises, so nothing is dropped or repeated.
// Reset clears all valid bits and loads the settings defaults: window low 0,
// scale one, gamma step 0, highlighting on at level 0, all selects channel 0.
module pixel_tone_map_gamma_quantize_core import ptmgq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] sample_zero_i,
  input  logic signed [31:0] sample_one_i,
  input  logic signed [31:0] sample_two_i,
  input  logic signed [31:0] sample_three_i,
  input  logic [3:0]         bad_flags_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         red_out_o,
  output logic [7:0]         green_out_o,
  output logic [7:0]         blue_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  // settings registers
  logic signed [31:0] window_low_q;
  logic [31:0]        window_scale_q;
  logic signed [5:0]  gamma_step_q;
  logic               hl_enable_q;
  logic [16:0]        hl_level_q;
  logic [SelWidth-1:0] sel_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_low_q   <= '0;
      window_scale_q <= 32'd65536;
      gamma_step_q   <= '0;
      hl_enable_q    <= 1'b1;
      hl_level_q     <= '0;
      sel_q[0]       <= '0;
      sel_q[1]       <= '0;
      sel_q[2]       <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ptmgq_cfg_idx_e'(cfg_index_i))
        CfgWindowLow:   window_low_q   <= cfg_data_i;
        CfgWindowScale: window_scale_q <= cfg_data_i;
        CfgGammaStep:   gamma_step_q   <= cfg_data_i[5:0];
        CfgHlEnable:    hl_enable_q    <= cfg_data_i[0];
        CfgHlLevel:     hl_level_q     <= cfg_data_i[16:0];
        CfgSelRed:      sel_q[0]       <= cfg_data_i[SelWidth-1:0];
        CfgSelGreen:    sel_q[1]       <= cfg_data_i[SelWidth-1:0];
        CfgSelBlue:     sel_q[2]       <= cfg_data_i[SelWidth-1:0];
      endcase
    end
  end

  ptmgq_cfg_t lane_cfg;
  assign lane_cfg = '{window_low: window_low_q, window_scale: window_scale_q,
                      gamma_step: gamma_step_q};

  // pipeline advance, frozen while the skid holds a result
  logic adv;
  logic skid_vld_q;
  logic out_vld_q;
  logic vld_q [0:LaneDepth];

  assign adv        = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= LaneDepth; k++) vld_q[k] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k <= LaneDepth; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // channel pick, bad flag and highlight test
  logic signed [31:0]  smp [NumChannels];
  logic [SelWidth-1:0] chan [3];
  logic signed [31:0]  pick [3];
  logic                bad_c;
  logic                low_c;

  assign smp[0] = sample_zero_i;
  assign smp[1] = sample_one_i;
  assign smp[2] = sample_two_i;
  assign smp[3] = sample_three_i;

  always_comb begin
    bad_c = 1'b0;
    low_c = 1'b1;
    for (int k = 0; k < 3; k++) begin
      chan[k] = (int'(sel_q[k]) < NumChannels) ? sel_q[k] : '0;
      pick[k] = smp[chan[k]];
      if (bad_flags_i[chan[k]]) bad_c = 1'b1;
      if (pick[k] < 0 || pick[k] > $signed({15'd0, hl_level_q})) low_c = 1'b0;
    end
  end

  logic signed [31:0] pick_q [3];
  logic               bad_q  [0:LaneDepth];
  logic               low_q  [0:LaneDepth];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) pick_q[k] <= pick[k];
      bad_q[0] <= bad_c;
      low_q[0] <= low_c;
      for (int k = 1; k <= LaneDepth; k++) begin
        bad_q[k] <= bad_q[k-1];
        low_q[k] <= low_q[k-1];
      end
    end
  end

  // colour lanes
  logic [7:0] lane_byte [3];
  for (genvar c = 0; c < 3; c++) begin : g_lane
    ptmgq_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (adv),
      .cfg_i    (lane_cfg),
      .sample_i (pick_q[c]),
      .byte_o   (lane_byte[c])
    );
  end

  // marking overrides
  logic [7:0] res [3];
  always_comb begin
    priority if (bad_q[LaneDepth]) begin
      res[0] = 8'd255;
      res[1] = 8'd255;
      res[2] = 8'd0;
    end else if (hl_enable_q && low_q[LaneDepth]) begin
      res[0] = 8'd127;
      res[1] = 8'd0;
      res[2] = 8'd127;
    end else begin
      res = lane_byte;
    end
  end

  // output register and skid
  logic       out_take;
  logic [7:0] out_q  [3];
  logic [7:0] skid_q [3];
  assign out_take = out_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) skid_vld_q <= 1'b0;
    end else if (vld_q[LaneDepth]) begin
      if (!out_vld_q || out_take) out_vld_q <= 1'b1;
      else                        skid_vld_q <= 1'b1;
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) out_q <= skid_q;
    end else if (vld_q[LaneDepth]) begin
      if (!out_vld_q || out_take) out_q  <= res;
      else                        skid_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign red_out_o   = out_q[0];
  assign green_out_o = out_q[1];
  assign blue_out_o  = out_q[2];

  // skid is only used behind a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_vld_q |-> out_vld_q)
    else $error("skid holds a result while output register is empty");

  // an unstalled receiver always frees the skid
  assert property (@(posedge clk_i) disable iff (!rst_ni) !out_stall_i |=> !skid_vld_q)
    else $error("skid still full after receiver took a result");

  // an accepted request enters the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted request lost at pipeline entry");

  // skid fills only when the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(skid_vld_q) |-> $past(out_stall_i))
    else $error("skid filled without a receiver stall");

endmodule
